FILE: src/b32div_pkg.sv
// Package for the binary32 restoring divider: constants, pipeline types, helpers.
// Used by the stage module and the top level; no dependencies.
package b32div_pkg;

   localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
   localparam logic [31:0] ABS_MASK   = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX_FINITE = 32'h7F7F_FFFF;
   localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
   localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
   localparam logic [31:0] MIN_NORMAL = 32'h0080_0000;
   localparam logic [31:0] EXP_OFFSET = 32'd125;
   localparam int          STEPS      = 25;
   localparam int          STEPS_PER_STAGE_DEFAULT = 4;

   // one item in flight through the recurrence
   typedef struct packed {
      logic        special;
      logic [31:0] result;   // special value, or sign|exponent field
      logic [24:0] rem;
      logic [23:0] den;
      logic [24:0] quo;
   } stage_type;

   function automatic logic [4:0] lead_zeros(input logic [31:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 5'(31 - i);
      end
      return n;
   endfunction

endpackage

FILE: src/binary32_restoring_divider_top.sv
// Top level of the binary32 restoring divider: front end, step pipeline, rounding.
// Depends on b32div_pkg and b32div_stage.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_dividend, req_divisor
//   rsp     | out       | rsp_valid, rsp_ready, rsp_quotient
//
// One item per cycle while the output register is free or taken; registers in order:
// front end, step stages of STEPS_PER_STAGE restoring steps each, rounding/output register.
// The whole pipeline holds when the output register is full and not taken.
// Synchronous reset clears valid bits only.
module binary32_restoring_divider_top import b32div_pkg::*; #(
   parameter int STEPS_PER_STAGE = STEPS_PER_STAGE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_dividend,
   input  logic [31:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_quotient
);

   localparam int NSTAGE = (STEPS - 1) / STEPS_PER_STAGE;

   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // front end: specials, normalisation, first quotient bit
   stage_type front_in;
   always_comb begin
      logic [31:0] mx, my, sign, big, sig_x, sig_y, biased;
      logic [4:0]  lx, ly;
      logic [31:0] sx, sy, ge;
      mx   = req_dividend & ABS_MASK;
      my   = req_divisor & ABS_MASK;
      sign = (req_dividend ^ req_divisor) & SIGN_MASK;
      big  = (mx > my) ? mx : my;
      lx   = lead_zeros(mx);
      ly   = lead_zeros(my);
      sx   = (lx > 5'd8) ? 32'(lx) : 32'd8;
      sy   = (ly > 5'd8) ? 32'(ly) : 32'd8;
      sig_x = (req_dividend << sx[4:0]) | SIGN_MASK;
      sig_y = (req_divisor  << sy[4:0]) | SIGN_MASK;
      ge    = {31'd0, sig_x >= sig_y};
      biased = ((mx >> 23) - {31'd0, mx >= MIN_NORMAL})
             - ((my >> 23) - {31'd0, my >= MIN_NORMAL})
             - (sx - sy) + (EXP_OFFSET + ge);
      front_in.den = sig_y[31:8];
      front_in.rem = 25'((sig_x >> (32'd7 + ge)) - {8'd0, sig_y[31:8]});
      front_in.quo = 25'd1;
      front_in.special = ((((mx - 32'd1) > (my - 32'd1)) ? (mx - 32'd1) : (my - 32'd1))
                          >= MAX_FINITE);
      if (front_in.special) begin
         if (big > INF_BITS || mx == my) front_in.result = sign | INF_BITS | QUIET_BIT | big;
         else if (mx < my)               front_in.result = sign;
         else                            front_in.result = sign | INF_BITS;
      end else begin
         front_in.result = sign | (biased << 23);
      end
   end

   logic      front_valid_ff;
   stage_type front_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (enable) begin
         front_valid_ff <= req_valid;
      end
      if (enable) front_ff <= front_in;
   end

   logic      vchain [NSTAGE+1];
   stage_type dchain [NSTAGE+1];
   assign vchain[0] = front_valid_ff;
   assign dchain[0] = front_ff;

   for (genvar g = 0; g < NSTAGE; g++) begin : g_step
      b32div_stage #(.NSTEPS(STEPS_PER_STAGE)) u_stage (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(vchain[g]), .data_in(dchain[g]),
         .valid_out(vchain[g+1]), .data_out(dchain[g+1])
      );
   end

   // remaining steps, rounding and packing
   logic [31:0] rsp_quotient_in;
   always_comb begin
      stage_type   d;
      logic [25:0] twice;
      d = dchain[NSTAGE];
      for (int k = 0; k < (STEPS - 1) - NSTAGE * STEPS_PER_STAGE; k++) begin
         twice = {d.rem, 1'b0};
         if (twice < {2'b00, d.den}) begin
            d.quo = {d.quo[23:0], 1'b0};
            d.rem = twice[24:0];
         end else begin
            d.quo = {d.quo[23:0], 1'b1};
            d.rem = 25'(twice - {2'b00, d.den});
         end
      end
      if (d.special) rsp_quotient_in = d.result;
      else rsp_quotient_in = d.result + {8'd0, d.quo[24:1]} + {31'd0, d.quo[0]};
   end

   logic        rsp_valid_ff;
   logic [31:0] rsp_quotient_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= vchain[NSTAGE];
      end
      if (enable) rsp_quotient_ff <= rsp_quotient_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quotient = rsp_quotient_ff;

endmodule

FILE: src/b32div_stage.sv
// A group of restoring radix-2 steps with its own valid/hold register.
// Depends on b32div_pkg.
module b32div_stage import b32div_pkg::*; #(
   parameter int NSTEPS = STEPS_PER_STAGE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      valid_in,
   input  stage_type data_in,
   output logic      valid_out,
   output stage_type data_out
);

   logic      valid_ff;
   stage_type data_ff, data_in_next;

   always_comb begin
      logic [25:0] twice;
      data_in_next = data_in;
      for (int k = 0; k < NSTEPS; k++) begin
         twice = {data_in_next.rem, 1'b0};
         if (twice < {2'b00, data_in_next.den}) begin
            data_in_next.quo = {data_in_next.quo[23:0], 1'b0};
            data_in_next.rem = twice[24:0];
         end else begin
            data_in_next.quo = {data_in_next.quo[23:0], 1'b1};
            data_in_next.rem = 25'(twice - {2'b00, data_in_next.den});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) data_ff <= data_in_next;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

FILE: src/b32div_checker.sv
// Port-level checker for the binary32 divider, bound to the top level.
// Depends on nothing but the top level's ports.
module b32div_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_quotient
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient))
      else $error("result dropped or changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind binary32_restoring_divider_top b32div_checker u_b32div_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_quotient(rsp_quotient)
);

FILE: bench/quotient_checker.sv
// Checker for the binary32 restoring divider: watches both channels, predicts each quotient.
// Depends on nothing but the port signals of binary32_restoring_divider_top.
module quotient_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_dividend,
   input  logic [31:0] req_divisor,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_quotient,
   output int          fail_count,
   output int          pending
);

   localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
   localparam logic [31:0] MAG_MASK   = 32'h7FFF_FFFF;
   localparam logic [31:0] TOP_FINITE = 32'h7F7F_FFFF;
   localparam logic [31:0] INF_PAT    = 32'h7F80_0000;
   localparam logic [31:0] QNAN_BIT   = 32'h0040_0000;
   localparam logic [31:0] NORM_MIN   = 32'h0080_0000;
   localparam logic [31:0] BIAS_ADJ   = 32'd125;

   logic [31:0] quotients_due[$];

   function automatic logic [31:0] umax(input logic [31:0] p, input logic [31:0] q);
      return (p > q) ? p : q;
   endfunction

   function automatic logic [31:0] clz32(input logic [31:0] v);
      logic [31:0] n;
      n = 32'd32;
      for (int i = 0; i < 32; i++) if (v[i]) n = 32'(31 - i);
      return n;
   endfunction

   function automatic logic [31:0] predict_quotient(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, sgn, big, sa, sb, na, nb, ge, ea, eb, xn, yn, biased;
      logic [31:0] num, den, quo, rem, twice;
      ma = a & MAG_MASK;
      mb = b & MAG_MASK;
      sgn = (a ^ b) & SIGN_BIT;
      if (umax(ma - 1, mb - 1) >= TOP_FINITE) begin
         big = umax(ma, mb);
         if (big > INF_PAT || ma == mb) return sgn | INF_PAT | QNAN_BIT | big;
         if (ma < mb) return sgn;
         return sgn | INF_PAT;
      end
      sa = umax(clz32(ma), 8);
      sb = umax(clz32(mb), 8);
      na = (a << sa) | SIGN_BIT;
      nb = (b << sb) | SIGN_BIT;
      ge = (na >= nb) ? 1 : 0;
      ea = ma >> 23;
      eb = mb >> 23;
      xn = (ma >= NORM_MIN) ? 1 : 0;
      yn = (mb >= NORM_MIN) ? 1 : 0;
      biased = (ea - xn) - (eb - yn) - (sa - sb) + (BIAS_ADJ + ge);
      num = na >> (7 + ge);
      den = nb >> 8;
      quo = 1;
      rem = num - den;
      for (int k = 1; k < 25; k++) begin
         twice = rem << 1;
         if (twice < den) begin
            quo = quo << 1;
            rem = twice;
         end else begin
            quo = (quo << 1) + 1;
            rem = twice - den;
         end
      end
      return (sgn | (biased << 23)) + ((quo >> 1) + (quo & 1));
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch: %s got %08h want %08h", what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            quotients_due.push_back(predict_quotient(req_dividend, req_divisor));
         if (rsp_valid && rsp_ready) begin
            if (quotients_due.size() == 0) report("unexpected item", rsp_quotient, 0);
            else begin
               logic [31:0] want;
               want = quotients_due.pop_front();
               if (rsp_quotient !== want) report("quotient", rsp_quotient, want);
            end
         end
      end
      pending = quotients_due.size();
   end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the binary32 restoring divider: clock, reset, stimulus and verdict.
// Depends on binary32_restoring_divider_top and quotient_checker.
module tb_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_dividend = 0;
   logic [31:0] req_divisor = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_quotient;
   int          fail_count;
   int          pending;
   bit          sink_quiet = 0;
   int          rsp_wait = 0;

   always #5 clock = ~clock;

   binary32_restoring_divider_top DUT (.*);
   quotient_checker u_checker (.*);

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[30:0] = 31'd0;                         // zero
         1: v[30:23] = 8'hFF;                        // infinity or NaN
         2: v = {v[31], 8'hFF, 23'd0};               // exact infinity
         3: v[30:23] = 8'd0;                         // subnormal
         4: v[30:0] = 31'($urandom_range(1, 255));   // tiny subnormal
         5: v[30:23] = 8'($urandom_range(100, 154));
         default: ;
      endcase
      return v;
   endfunction

   // hold valid across back-to-back items; drop it only for an idle gap
   task automatic send(input logic [31:0] a, input logic [31:0] b);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_dividend <= a;
      req_divisor <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver: draw a wait after each item, none during quiet stretches
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 0;
         rsp_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) w = sink_quiet ? 0 : $urandom_range(0, 4);
         else w = (rsp_wait > 0) ? rsp_wait - 1 : 0;
         rsp_wait <= w;
         rsp_ready <= (w == 0);
      end
   end

   initial begin
      #2000000;
      $display("[binary32_restoring_divider_top] ERROR");
      $finish;
   end

   initial begin
      logic [31:0] edge_ops[12];
      edge_ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'h7F80_0001, 32'h0000_0001, 32'h007F_FFFF,
                   32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hFFFF_FFFF};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 5; j++)
            send(edge_ops[(i * 7 + j * 3) % 12], edge_ops[(j * 5 + i) % 12]);
      for (int n = 0; n < 1700; n++) begin
         if (n % 300 == 150) sink_quiet <= ~sink_quiet;
         if (n == 600) begin
            // drain fully once
            req_valid <= 0;
            @(posedge clock);
            wait (pending == 0);
         end
         send(random_operand(), random_operand());
      end
      req_valid <= 0;
      sink_quiet <= 1;
      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("[binary32_restoring_divider_top] OK");
      else $display("[binary32_restoring_divider_top] ERROR");
      $finish;
   end

endmodule
